@@ src/keypad_time_entry_fsm_assert.svh @@
// Assertion macros shared by the checker of the keypad time entry block.
// Holds macro definitions only; no dependencies.
`ifndef KEYPAD_TIME_ENTRY_FSM_ASSERT_SVH
`define KEYPAD_TIME_ENTRY_FSM_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kte assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kte assertion failed");

`endif

@@ src/kte_pkg.sv @@
// Package for the keypad time entry block: cursor positions, key codes,
// digit limits and a small divide-by-ten helper. No dependencies.
package kte_pkg;

  typedef enum logic [2:0] {
    POS_BEGIN  = 3'd0,
    POS_HOUR_T = 3'd1,
    POS_HOUR_U = 3'd2,
    POS_MIN_T  = 3'd3,
    POS_MIN_U  = 3'd4,
    POS_SEC_T  = 3'd5,
    POS_SEC_U  = 3'd6,
    POS_DONE   = 3'd7
  } pos_e;

  localparam logic       KIND_START  = 1'b0;
  localparam logic       KIND_KEY    = 1'b1;

  localparam logic [1:0] KEY_CHAR    = 2'd0;
  localparam logic [1:0] KEY_BACK    = 2'd1;
  localparam logic [1:0] KEY_CONFIRM = 2'd2;

  localparam logic [7:0] CHAR_ZERO   = 8'd48;
  localparam logic [7:0] CHAR_NINE   = 8'd57;

  localparam logic [3:0] HOUR_TENS_MAX = 4'd2;
  localparam logic [3:0] MIN_TENS_MAX  = 4'd5;
  localparam logic [6:0] HOUR_MAX      = 7'd23;
  localparam logic [6:0] MIN_MAX       = 7'd59;

  localparam int unsigned SOD_W = 17;

  // Tens digit of a value below 64, by a short compare chain.
  function automatic logic [2:0] div10(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

endpackage

@@ src/keypad_time_entry_fsm.sv @@
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | kind, key_class, key_char, load_*
// out     | output    | out_valid_o / out_stall_i | accepted .. seconds_of_day
//
// One beat in gives exactly one beat out, offered in the cycle after acceptance.
// A new beat can be accepted every cycle unless the input is stalled; the next-state logic is a single pass.
// The input is stalled only while a result is held and the output is stalled.
// Reset puts the cursor at the begin position with the entry idle.
// Keypad time entry sequencer: top level. Uses kte_pkg.
module keypad_time_entry_fsm
  import kte_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic [1:0]           key_class_i,
  input  logic [7:0]           key_char_i,
  input  logic [4:0]           load_hour_i,
  input  logic [5:0]           load_minute_i,
  input  logic [5:0]           load_second_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic                 still_editing_o,
  output logic                 finished_o,
  output logic                 cancelled_o,
  output logic [2:0]           cursor_pos_o,
  output logic [4:0]           hour_now_o,
  output logic [5:0]           minute_now_o,
  output logic [5:0]           second_now_o,
  output logic [SOD_W-1:0]     seconds_of_day_o
);

  pos_e             pos_q, pos_d;
  logic [4:0]       hour_q, hour_d;
  logic [5:0]       minute_q, minute_d;
  logic [5:0]       second_q, second_d;
  logic             done_q, done_d;

  logic             out_valid_q;
  logic             acc_q, fin_q, can_q;
  logic             acc, fin, can;
  logic [SOD_W-1:0] sod_q, sod_d;

  logic             in_accept;
  logic             is_digit;
  logic [3:0]       dig;
  logic [5:0]       sel_val;
  logic [2:0]       sel_tens;
  logic [3:0]       sel_units;
  logic [6:0]       new_tens_val;
  logic [6:0]       new_units_val;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_digit = (key_char_i >= CHAR_ZERO) && (key_char_i <= CHAR_NINE);
  assign dig      = 4'(key_char_i - CHAR_ZERO);

  // The field under the cursor, split into its tens and units digits.
  always_comb begin
    unique case (pos_q) inside
      POS_HOUR_T, POS_HOUR_U: sel_val = {1'b0, hour_q};
      POS_MIN_T, POS_MIN_U:   sel_val = minute_q;
      default:                sel_val = second_q;
    endcase
  end

  assign sel_tens      = div10(sel_val);
  assign sel_units     = 4'(sel_val - 6'(6'(sel_tens) * 6'd10));
  assign new_tens_val  = 7'(dig) * 7'd10 + 7'(sel_units);
  assign new_units_val = 7'(sel_tens) * 7'd10 + 7'(dig);

  always_comb begin
    pos_d    = pos_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    done_d   = done_q;
    acc      = 1'b0;
    fin      = 1'b0;
    can      = 1'b0;
    if (in_accept) begin
      if (kind_i == KIND_START) begin
        hour_d   = load_hour_i;
        minute_d = load_minute_i;
        second_d = load_second_i;
        pos_d    = POS_BEGIN;
        done_d   = 1'b0;
        acc      = 1'b1;
      end else if (!done_q) begin
        if (pos_q == POS_BEGIN) begin
          pos_d = POS_HOUR_T;
          acc   = 1'b1;
        end else if (key_class_i == KEY_BACK) begin
          acc   = 1'b1;
          pos_d = pos_e'(pos_q - 3'd1);
          if (pos_q == POS_HOUR_T) begin
            can    = 1'b1;
            done_d = 1'b1;
          end
        end else if (key_class_i == KEY_CONFIRM) begin
          acc = 1'b1;
          if (pos_q == POS_SEC_U || pos_q == POS_DONE) begin
            pos_d  = POS_DONE;
            fin    = 1'b1;
            done_d = 1'b1;
          end else begin
            pos_d = pos_e'(pos_q + 3'd1);
          end
        end else if (is_digit) begin
          // Other key classes, including the unused code, count as characters.
          unique case (pos_q) inside
            POS_HOUR_T: begin
              if (dig <= HOUR_TENS_MAX) begin
                hour_d = 5'(new_tens_val);
                acc    = 1'b1;
              end
            end
            POS_HOUR_U: begin
              if (new_units_val <= HOUR_MAX) begin
                hour_d = 5'(new_units_val);
                acc    = 1'b1;
              end
            end
            POS_MIN_T: begin
              if (dig <= MIN_TENS_MAX) begin
                minute_d = 6'(new_tens_val);
                acc      = 1'b1;
              end
            end
            POS_MIN_U: begin
              if (new_units_val <= MIN_MAX) begin
                minute_d = 6'(new_units_val);
                acc      = 1'b1;
              end
            end
            POS_SEC_T: begin
              if (dig <= MIN_TENS_MAX) begin
                second_d = 6'(new_tens_val);
                acc      = 1'b1;
              end
            end
            POS_SEC_U: begin
              if (new_units_val <= MIN_MAX) begin
                second_d = 6'(new_units_val);
                acc      = 1'b1;
              end
            end
            POS_BEGIN, POS_DONE: begin
              acc = 1'b0;
            end
          endcase
          if (acc) begin
            pos_d = pos_e'(pos_q + 3'd1);
          end
        end
      end
    end
  end

  // The time only changes on a digit or a start, never on a confirm, so the held values are final.
  always_comb begin
    if (fin) begin
      sod_d = SOD_W'(hour_q) * SOD_W'(3600)
            + SOD_W'(minute_q) * SOD_W'(60)
            + SOD_W'(second_q);
    end else begin
      sod_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_BEGIN;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      done_q   <= 1'b1;
    end else begin
      pos_q    <= pos_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      acc_q <= acc;
      fin_q <= fin;
      can_q <= can;
      sod_q <= sod_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = acc_q;
  assign finished_o       = fin_q;
  assign cancelled_o      = can_q;
  assign still_editing_o  = !done_q;
  assign cursor_pos_o     = pos_q;
  assign hour_now_o       = hour_q;
  assign minute_now_o     = minute_q;
  assign second_now_o     = second_q;
  assign seconds_of_day_o = sod_q;

endmodule

@@ src/kte_checker.sv @@
// Port-level checker for the keypad time entry block, bound to the top level.
// Uses kte_pkg and the macros of keypad_time_entry_fsm_assert.svh.
`include "keypad_time_entry_fsm_assert.svh"

module kte_checker
  import kte_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             accepted_o,
  input logic             still_editing_o,
  input logic             finished_o,
  input logic             cancelled_o,
  input logic [2:0]       cursor_pos_o,
  input logic [SOD_W-1:0] seconds_of_day_o
);

  // A stalled result beat stays offered.
  `KTE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `KTE_ASSERT_NOW(a_fin_can_excl, clk_i, rst_ni, out_valid_o, !(finished_o && cancelled_o))

  // A finished entry sits on the confirmed position and has stopped editing.
  `KTE_ASSERT_NOW(a_fin_pos, clk_i, rst_ni, out_valid_o && finished_o,
                  accepted_o && !still_editing_o && cursor_pos_o == POS_DONE)

  `KTE_ASSERT_NOW(a_can_pos, clk_i, rst_ni, out_valid_o && cancelled_o,
                  accepted_o && !still_editing_o && cursor_pos_o == POS_BEGIN)

  // The seconds count is only reported with a finish.
  `KTE_ASSERT_NOW(a_sod_zero, clk_i, rst_ni, out_valid_o && !finished_o, seconds_of_day_o == '0)

endmodule

bind keypad_time_entry_fsm kte_checker u_kte_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .accepted_o       (accepted_o),
  .still_editing_o  (still_editing_o),
  .finished_o       (finished_o),
  .cancelled_o      (cancelled_o),
  .cursor_pos_o     (cursor_pos_o),
  .seconds_of_day_o (seconds_of_day_o)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keypad_time_entry_fsm: directed and random keypad beats.
// Each result is checked against a local prediction. Depends on kte_pkg and the block only.
module testbench;
  import kte_pkg::*;

  localparam logic [1:0] KEY_SPARE   = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic       kind;
    logic [1:0] key_class;
    logic [7:0] key_char;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } keypad_beat_t;

  typedef struct packed {
    logic             accepted;
    logic             still_editing;
    logic             finished;
    logic             cancelled;
    logic [2:0]       cursor_pos;
    logic [4:0]       hour_now;
    logic [5:0]       minute_now;
    logic [5:0]       second_now;
    logic [SOD_W-1:0] seconds_of_day;
  } entry_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             kind_i = KIND_KEY;
  logic [1:0]       key_class_i = KEY_CHAR;
  logic [7:0]       key_char_i = 8'd0;
  logic [4:0]       load_hour_i = 5'd0;
  logic [5:0]       load_minute_i = 6'd0;
  logic [5:0]       load_second_i = 6'd0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             accepted_o;
  logic             still_editing_o;
  logic             finished_o;
  logic             cancelled_o;
  logic [2:0]       cursor_pos_o;
  logic [4:0]       hour_now_o;
  logic [5:0]       minute_now_o;
  logic [5:0]       second_now_o;
  logic [SOD_W-1:0] seconds_of_day_o;

  // Predicted state of the entry sequencer.
  pos_e       cur_pos = POS_BEGIN;
  logic [4:0] hour_q = 5'd0;
  logic [5:0] min_q = 6'd0;
  logic [5:0] sec_q = 6'd0;
  bit         entry_idle = 1'b1;

  entry_result_t expected_q[$];
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   fail_count = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   beats_sent = 0;
  int unsigned   starts_seen = 0;
  int unsigned   finishes_seen = 0;
  int unsigned   cancels_seen = 0;
  int unsigned   rejects_seen = 0;

  keypad_time_entry_fsm uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .key_class_i      (key_class_i),
    .key_char_i       (key_char_i),
    .load_hour_i      (load_hour_i),
    .load_minute_i    (load_minute_i),
    .load_second_i    (load_second_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .still_editing_o  (still_editing_o),
    .finished_o       (finished_o),
    .cancelled_o      (cancelled_o),
    .cursor_pos_o     (cursor_pos_o),
    .hour_now_o       (hour_now_o),
    .minute_now_o     (minute_now_o),
    .second_now_o     (second_now_o),
    .seconds_of_day_o (seconds_of_day_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result of one accepted beat and advances the predicted state.
  function automatic entry_result_t predict_entry(input keypad_beat_t b);
    entry_result_t r;
    int unsigned   d;
    int unsigned   v;
    bit            ok;
    r = '0;
    d = 0;
    v = 0;
    ok = 1'b0;
    beats_sent++;
    if (b.kind == KIND_START) begin
      hour_q = b.load_hour;
      min_q = b.load_minute;
      sec_q = b.load_second;
      cur_pos = POS_BEGIN;
      entry_idle = 1'b0;
      r.accepted = 1'b1;
      starts_seen++;
    end else if (!entry_idle) begin
      if (cur_pos == POS_BEGIN) begin
        cur_pos = POS_HOUR_T;
        r.accepted = 1'b1;
      end else if (b.key_class == KEY_BACK) begin
        r.accepted = 1'b1;
        cur_pos = pos_e'(cur_pos - 3'd1);
        if (cur_pos == POS_BEGIN) begin
          r.cancelled = 1'b1;
          entry_idle = 1'b1;
          cancels_seen++;
        end
      end else if (b.key_class == KEY_CONFIRM) begin
        r.accepted = 1'b1;
        // A digit on seconds-units leaves the cursor on the confirmed slot still editing.
        if (cur_pos >= POS_SEC_U) begin
          cur_pos = POS_DONE;
          r.finished = 1'b1;
          entry_idle = 1'b1;
          r.seconds_of_day = SOD_W'(3600 * hour_q + 60 * min_q + sec_q);
          finishes_seen++;
        end else begin
          cur_pos = pos_e'(cur_pos + 3'd1);
        end
      end else if (b.key_char >= CHAR_ZERO && b.key_char <= CHAR_NINE) begin
        d = 32'(b.key_char - CHAR_ZERO);
        case (cur_pos)
          POS_HOUR_T: begin
            ok = d <= HOUR_TENS_MAX;
            v = 10 * d + hour_q % 10;
          end
          POS_HOUR_U: begin
            v = (hour_q / 10) * 10 + d;
            ok = v <= HOUR_MAX;
          end
          POS_MIN_T: begin
            ok = d <= MIN_TENS_MAX;
            v = 10 * d + min_q % 10;
          end
          POS_MIN_U: begin
            v = (min_q / 10) * 10 + d;
            ok = v <= MIN_MAX;
          end
          POS_SEC_T: begin
            ok = d <= MIN_TENS_MAX;
            v = 10 * d + sec_q % 10;
          end
          POS_SEC_U: begin
            v = (sec_q / 10) * 10 + d;
            ok = v <= MIN_MAX;
          end
          default: ok = 1'b0;
        endcase
        if (ok) begin
          if (cur_pos <= POS_HOUR_U) hour_q = 5'(v);
          else if (cur_pos <= POS_MIN_U) min_q = 6'(v);
          else sec_q = 6'(v);
          cur_pos = pos_e'(cur_pos + 3'd1);
          r.accepted = 1'b1;
        end
      end
      if (!r.accepted) rejects_seen++;
    end
    r.still_editing = !entry_idle;
    r.cursor_pos = cur_pos;
    r.hour_now = hour_q;
    r.minute_now = min_q;
    r.second_now = sec_q;
    return r;
  endfunction

  function automatic keypad_beat_t key_beat(input logic [1:0] cls, input logic [7:0] ch);
    keypad_beat_t b;
    b.kind = KIND_KEY;
    b.key_class = cls;
    b.key_char = ch;
    // Load fields are don't-care on a key beat, so they carry noise.
    b.load_hour = 5'($urandom);
    b.load_minute = 6'($urandom);
    b.load_second = 6'($urandom);
    return b;
  endfunction

  function automatic keypad_beat_t start_beat(input logic [4:0] h, input logic [5:0] m,
                                              input logic [5:0] s);
    keypad_beat_t b;
    b.kind = KIND_START;
    b.key_class = 2'($urandom);
    b.key_char = 8'($urandom);
    b.load_hour = h;
    b.load_minute = m;
    b.load_second = s;
    return b;
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned d);
    return 8'(CHAR_ZERO + d);
  endfunction

  // Offers one beat, with a random gap first, and holds it until it is taken.
  task automatic send_beat(input keypad_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= b.kind;
    key_class_i <= b.key_class;
    key_char_i <= b.key_char;
    load_hour_i <= b.load_hour;
    load_minute_i <= b.load_minute;
    load_second_i <= b.load_second;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(predict_entry(b));
  endtask

  task automatic test_directed_entry();
    send_beat(key_beat(KEY_CHAR, digit_char(5)));         // ignored: idle after reset
    send_beat(start_beat(5'd23, 6'd59, 6'd59));
    send_beat(key_beat(KEY_BACK, 8'd0));                  // any key leaves begin
    send_beat(key_beat(KEY_CHAR, digit_char(3)));         // hour tens too big
    send_beat(key_beat(KEY_CHAR, digit_char(2)));
    send_beat(key_beat(KEY_CHAR, digit_char(4)));         // hour 24 refused
    send_beat(key_beat(KEY_CHAR, digit_char(0)));
    send_beat(key_beat(KEY_CHAR, digit_char(6)));         // minute tens too big
    send_beat(key_beat(KEY_CHAR, CHAR_ZERO - 8'd1));      // just below the digits
    send_beat(key_beat(KEY_CHAR, CHAR_NINE + 8'd1));      // just above the digits
    send_beat(key_beat(KEY_CHAR, digit_char(5)));
    send_beat(key_beat(KEY_CHAR, digit_char(9)));
    send_beat(key_beat(KEY_SPARE, digit_char(0)));        // spare class acts as a character
    send_beat(key_beat(KEY_CHAR, digit_char(9)));         // cursor reaches the confirmed slot
    send_beat(key_beat(KEY_CHAR, digit_char(7)));         // no digit fits there
    send_beat(key_beat(KEY_BACK, 8'hFF));
    send_beat(key_beat(KEY_CONFIRM, 8'h00));              // finish
    send_beat(key_beat(KEY_CONFIRM, 8'h00));              // ignored after finish
    send_beat(start_beat(5'h1F, 6'h3F, 6'h3F));           // out-of-range load kept as is
    send_beat(key_beat(KEY_CONFIRM, 8'hFF));
    send_beat(key_beat(KEY_BACK, 8'h00));                 // cancel
    send_beat(key_beat(KEY_CHAR, digit_char(1)));         // ignored after cancel
    send_beat(start_beat(5'd0, 6'd0, 6'd0));
  endtask

  // Mostly well-formed editing sessions with random content, mixed with noise.
  task automatic test_random_sessions(input int unsigned count);
    int unsigned  done_items;
    int unsigned  pick;
    keypad_beat_t b;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(99);
      if (entry_idle && pick >= 85) begin
        b = key_beat(2'($urandom), 8'($urandom));
      end else if (entry_idle || pick < 6) begin
        if ($urandom_range(9) == 0)
          b = start_beat(5'($urandom), 6'($urandom), 6'($urandom));
        else
          b = start_beat(5'($urandom_range(23)), 6'($urandom_range(59)),
                         6'($urandom_range(59)));
      end else if (pick < 56) begin
        b = key_beat(KEY_CHAR,
                     digit_char($urandom_range(1) ? $urandom_range(9) : $urandom_range(2)));
      end else if (pick < 74) begin
        b = key_beat(KEY_CONFIRM, 8'($urandom));
      end else if (pick < 82) begin
        b = key_beat(KEY_BACK, 8'($urandom));
      end else if (pick < 92) begin
        b = key_beat(KEY_CHAR, 8'($urandom));
      end else begin
        b = key_beat(KEY_SPARE, $urandom_range(1) ? digit_char($urandom_range(9))
                                                  : 8'($urandom));
      end
      if (b.kind == KIND_START || !entry_idle) done_items++;
      send_beat(b);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    entry_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat arrived with nothing expected", $time);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        compare_field("accepted", 32'(want.accepted), 32'(accepted_o));
        compare_field("still_editing", 32'(want.still_editing), 32'(still_editing_o));
        compare_field("finished", 32'(want.finished), 32'(finished_o));
        compare_field("cancelled", 32'(want.cancelled), 32'(cancelled_o));
        compare_field("cursor_pos", 32'(want.cursor_pos), 32'(cursor_pos_o));
        compare_field("hour_now", 32'(want.hour_now), 32'(hour_now_o));
        compare_field("minute_now", 32'(want.minute_now), 32'(minute_now_o));
        compare_field("second_now", 32'(want.second_now), 32'(second_now_o));
        compare_field("seconds_of_day", 32'(want.seconds_of_day), 32'(seconds_of_day_o));
      end
    end
  end

  // Ends a hung run: too long with no beat moving on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 24;
    recv_idle_pct = 49;
    test_directed_entry();
    test_random_sessions(283);
    send_idle_pct = 49;
    recv_idle_pct = 24;
    test_random_sessions(283);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sessions(284);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Ran %0d beats: %0d entries started, %0d finished, %0d cancelled,",
             beats_sent, starts_seen, finishes_seen, cancels_seen);
    $display("%0d keys refused while editing; %0d mismatches.", rejects_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
